// File: src/argf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// argf_pkg
// Shared types and constants of the ARMA residual and gradient filter.
// ----------------------------------------------------------------------------
package argf_pkg;

    localparam int LAGS        = 2;   // lag slots held per history
    localparam int NPART       = 5;   // constant, two AR and two MA partials
    localparam int LAG_W       = $clog2(LAGS);
    localparam int PART_W      = $clog2(NPART + 1);
    localparam int ACC_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int COEF_RESET  = 6554;
    localparam int ORDER_RESET = 1;

    localparam int DEF_MAX_ORDER  = 2;
    localparam int DEF_DATA_WIDTH = 32;
    localparam int DEF_FRAC_BITS  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AR_ORDER    = 3'd0,
        CFG_MA_ORDER    = 3'd1,
        CFG_CONST       = 3'd2,
        CFG_AR_COEF_ONE = 3'd3,
        CFG_AR_COEF_TWO = 3'd4,
        CFG_MA_COEF_ONE = 3'd5,
        CFG_MA_COEF_TWO = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_Y,      // y * 1.0
        OP_C,      // - c * 1.0
        OP_AR,     // - ar[i] * y[t-1-i]
        OP_MA_E,   // - ma[i] * e[t-1-i]
        OP_BASE,   // base of partial k times 1.0
        OP_MA_D,   // - ma[i] * D_k[t-1-i]
        OP_SCORE,  // - D_k * e
        OP_SSE     // square_sum + e * e
    } t_mac_op;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_ACC,
        SRC_SSE
    } t_acc_src;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECIDE,
        S_E_Y,
        S_E_C,
        S_E_AR,
        S_E_MA,
        S_E_DRAIN,
        S_E_WB,
        S_D_BASE,
        S_D_MA,
        S_D_DRAIN,
        S_D_WB,
        S_S_OP,
        S_S_DRAIN,
        S_S_WB,
        S_SSE,
        S_COMMIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              load;      // take input word
        logic              mac_en;    // issue one multiply
        t_mac_op           op;
        logic [LAG_W-1:0]  lag;
        logic [PART_W-1:0] part;
        logic              wb_err;
        logic              wb_der;
        logic              wb_sc;
        logic              commit;    // shift histories
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic       warm;      // still in warm-up
        logic [1:0] p;         // clamped orders
        logic [1:0] q;
        logic       mac_busy;  // accumulate stage holds a term
        logic       out_free;
    } t_status;

endpackage
`default_nettype wire

// File: src/argf_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// argf_if
// Channel interfaces: sample input, result output and register writes.
// ----------------------------------------------------------------------------
interface argf_smp_if #(parameter int DATA_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sample;
    logic                         series_start;
    modport source (output valid, output sample, output series_start, input ready);
    modport sink   (input valid, input sample, input series_start, output ready);
endinterface

interface argf_res_if #(parameter int DATA_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] forecast_error;
    logic signed [DATA_WIDTH-1:0] deriv_const;
    logic signed [DATA_WIDTH-1:0] deriv_ar_one;
    logic signed [DATA_WIDTH-1:0] deriv_ar_two;
    logic signed [DATA_WIDTH-1:0] deriv_ma_one;
    logic signed [DATA_WIDTH-1:0] deriv_ma_two;
    logic signed [DATA_WIDTH-1:0] score_const;
    logic signed [DATA_WIDTH-1:0] score_ar_one;
    logic signed [DATA_WIDTH-1:0] score_ar_two;
    logic signed [DATA_WIDTH-1:0] score_ma_one;
    logic signed [DATA_WIDTH-1:0] score_ma_two;
    logic signed [63:0]           half_neg_sse;
    modport source (output valid, output forecast_error, output deriv_const,
                    output deriv_ar_one, output deriv_ar_two, output deriv_ma_one,
                    output deriv_ma_two, output score_const, output score_ar_one,
                    output score_ar_two, output score_ma_one, output score_ma_two,
                    output half_neg_sse, input ready);
    modport sink   (input valid, input forecast_error, input deriv_const,
                    input deriv_ar_one, input deriv_ar_two, input deriv_ma_one,
                    input deriv_ma_two, input score_const, input score_ar_one,
                    input score_ar_two, input score_ma_one, input score_ma_two,
                    input half_neg_sse, output ready);
endinterface

interface argf_cfg_if #(parameter int DATA_WIDTH = 32);
    logic                  valid;
    logic                  ready;
    logic [2:0]            index;
    logic [DATA_WIDTH-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: src/argf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// argf_ctrl
// Sequencer issuing MAC, write-back and commit commands per sample.
// ----------------------------------------------------------------------------
module argf_ctrl
    import argf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state            r_state, n_state;
    logic [LAG_W-1:0]  r_i, n_i;
    logic [PART_W-1:0] r_k, n_k;
    logic [PART_W-1:0] w_next_k;

    function automatic logic part_active(input logic [PART_W-1:0] k,
                                         input logic [1:0] p, input logic [1:0] q);
        logic act;
        if (k == '0)
            act = 1'b1;
        else if (k <= PART_W'(LAGS))
            act = (k - PART_W'(1)) < PART_W'(p);
        else
            act = (k - PART_W'(1 + LAGS)) < PART_W'(q);
        return act;
    endfunction

    always_comb begin
        w_next_k = PART_W'(NPART);
        for (int j = NPART - 1; j >= 0; j--) begin
            if ((PART_W'(j) > r_k) && part_active(PART_W'(j), i_status.p, i_status.q))
                w_next_k = PART_W'(j);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_k        = r_k;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.op   = OP_Y;
        o_cmd.lag  = r_i;
        o_cmd.part = r_k;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_i     = '0;
                n_k     = '0;
                n_state = i_status.warm ? S_COMMIT : S_E_Y;
            end
            S_E_Y: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.op     = OP_Y;
                n_state      = S_E_C;
            end
            S_E_C: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.op     = OP_C;
                if (i_status.p != 2'd0)
                    n_state = S_E_AR;
                else if (i_status.q != 2'd0)
                    n_state = S_E_MA;
                else
                    n_state = S_E_DRAIN;
            end
            S_E_AR: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.op     = OP_AR;
                if (2'(r_i) + 2'd1 == i_status.p) begin
                    n_i     = '0;
                    n_state = (i_status.q != 2'd0) ? S_E_MA : S_E_DRAIN;
                end else begin
                    n_i = r_i + LAG_W'(1);
                end
            end
            S_E_MA: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.op     = OP_MA_E;
                if (2'(r_i) + 2'd1 == i_status.q) begin
                    n_i     = '0;
                    n_state = S_E_DRAIN;
                end else begin
                    n_i = r_i + LAG_W'(1);
                end
            end
            S_E_DRAIN: begin
                n_state = S_E_WB;
            end
            S_E_WB: begin
                o_cmd.wb_err = 1'b1;
                n_state      = S_D_BASE;
            end
            S_D_BASE: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.op     = OP_BASE;
                n_i          = '0;
                n_state      = (i_status.q != 2'd0) ? S_D_MA : S_D_DRAIN;
            end
            S_D_MA: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.op     = OP_MA_D;
                if (2'(r_i) + 2'd1 == i_status.q) begin
                    n_i     = '0;
                    n_state = S_D_DRAIN;
                end else begin
                    n_i = r_i + LAG_W'(1);
                end
            end
            S_D_DRAIN: begin
                n_state = S_D_WB;
            end
            S_D_WB: begin
                o_cmd.wb_der = 1'b1;
                n_state      = S_S_OP;
            end
            S_S_OP: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.op     = OP_SCORE;
                n_state      = S_S_DRAIN;
            end
            S_S_DRAIN: begin
                n_state = S_S_WB;
            end
            S_S_WB: begin
                o_cmd.wb_sc = 1'b1;
                if (w_next_k < PART_W'(NPART)) begin
                    n_k     = w_next_k;
                    n_state = S_D_BASE;
                end else begin
                    n_state = S_SSE;
                end
            end
            S_SSE: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.op     = OP_SSE;
                n_state      = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: src/argf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// argf_datapath
// Registers, histories, shared saturating MAC and result register.
// ----------------------------------------------------------------------------
module argf_datapath
    import argf_pkg::*;
#(
    parameter int MAX_ORDER  = DEF_MAX_ORDER,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_cmd                         i_cmd,
    output t_status                           o_status,
    // register writes
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [DATA_WIDTH-1:0]        i_cfg_data,
    // input word
    input  wire logic signed [DATA_WIDTH-1:0] i_sample,
    input  wire logic                         i_series_start,
    // result word
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic signed [DATA_WIDTH-1:0]      o_err,
    output logic signed [DATA_WIDTH-1:0]      o_der [NPART],
    output logic signed [DATA_WIDTH-1:0]      o_sc  [NPART],
    output logic signed [ACC_W-1:0]           o_half_neg_sse
);

    localparam int AW    = DATA_WIDTH + 1;
    localparam int PW    = 2 * AW;
    localparam int WW    = ((PW > ACC_W) ? PW : ACC_W) + 1;
    localparam int CAP   = (MAX_ORDER < LAGS) ? MAX_ORDER : LAGS;
    localparam int IDX_W = $clog2(MAX_ORDER + 1);

    localparam logic signed [AW-1:0] L_ONE =
        {{(AW - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [ACC_W-1:0] L_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] L_MIN = {1'b1, {(ACC_W - 1){1'b0}}};
    localparam logic signed [ACC_W-1:0] L_HALF =
        ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] L_DMAX = ACC_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W-1:0] L_DMIN = -L_DMAX - ACC_W'(1);

    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
            return s[ACC_W] ? L_MIN : L_MAX;
        return s[ACC_W-1:0];
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] to_data(
            input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] r;
        t = sat_add(acc, L_HALF);
        r = t >>> FRAC_BITS;
        if (r > L_DMAX)
            return L_DMAX[DATA_WIDTH-1:0];
        if (r < L_DMIN)
            return L_DMIN[DATA_WIDTH-1:0];
        return r[DATA_WIDTH-1:0];
    endfunction

    function automatic logic signed [AW-1:0] ext(input logic signed [DATA_WIDTH-1:0] v);
        return {v[DATA_WIDTH-1], v};
    endfunction

    // configuration
    logic [1:0]                   r_ar_order, r_ma_order;
    logic signed [DATA_WIDTH-1:0] r_const;
    logic signed [DATA_WIDTH-1:0] r_ar [LAGS];
    logic signed [DATA_WIDTH-1:0] r_ma [LAGS];

    // per-sample state
    logic signed [DATA_WIDTH-1:0] r_y;
    logic signed [DATA_WIDTH-1:0] r_sh [LAGS];
    logic signed [DATA_WIDTH-1:0] r_eh [LAGS];
    logic signed [DATA_WIDTH-1:0] r_dh [NPART][LAGS];
    logic signed [DATA_WIDTH-1:0] r_err;
    logic signed [DATA_WIDTH-1:0] r_der [NPART];
    logic signed [DATA_WIDTH-1:0] r_sc  [NPART];
    logic [IDX_W-1:0]             r_idx;
    logic signed [ACC_W-1:0]      r_ss;
    logic signed [ACC_W-1:0]      r_acc;

    // multiply stage
    logic                    r_p_valid;
    logic signed [ACC_W-1:0] r_p_term;
    t_acc_src                r_p_src;

    logic [1:0] w_p, w_q, w_maxlag;
    always_comb begin
        w_p      = (r_ar_order > 2'(CAP)) ? 2'(CAP) : r_ar_order;
        w_q      = (r_ma_order > 2'(CAP)) ? 2'(CAP) : r_ma_order;
        w_maxlag = (w_p > w_q) ? w_p : w_q;
    end

    assign o_status.p        = w_p;
    assign o_status.q        = w_q;
    assign o_status.warm     = 32'(r_idx) < 32'(w_maxlag);
    assign o_status.mac_busy = r_p_valid;
    assign o_status.out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ar_order <= 2'(ORDER_RESET);
            r_ma_order <= 2'(ORDER_RESET);
            r_const    <= '0;
            for (int i = 0; i < LAGS; i++) begin
                r_ar[i] <= DATA_WIDTH'(COEF_RESET);
                r_ma[i] <= DATA_WIDTH'(COEF_RESET);
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_AR_ORDER:    r_ar_order <= i_cfg_data[1:0];
                CFG_MA_ORDER:    r_ma_order <= i_cfg_data[1:0];
                CFG_CONST:       r_const    <= i_cfg_data;
                CFG_AR_COEF_ONE: r_ar[0]    <= i_cfg_data;
                CFG_AR_COEF_TWO: r_ar[1]    <= i_cfg_data;
                CFG_MA_COEF_ONE: r_ma[0]    <= i_cfg_data;
                CFG_MA_COEF_TWO: r_ma[1]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // operand selection
    logic [LAG_W-1:0]        w_sh_sel, w_eh_sel;
    logic signed [AW-1:0]    w_a, w_b;
    logic                    w_neg;
    t_acc_src                w_src;
    logic signed [PW-1:0]    w_prod;
    logic signed [WW-1:0]    w_prod_x;
    logic signed [ACC_W-1:0] w_prod_s, w_term;

    always_comb begin
        w_sh_sel = (i_cmd.op == OP_AR) ? i_cmd.lag : LAG_W'(i_cmd.part - PART_W'(1));
        w_eh_sel = (i_cmd.op == OP_MA_E) ? i_cmd.lag
                                         : LAG_W'(i_cmd.part - PART_W'(1 + LAGS));
        w_a   = L_ONE;
        w_b   = L_ONE;
        w_neg = 1'b1;
        w_src = SRC_ACC;
        case (i_cmd.op)
            OP_Y: begin
                w_a   = ext(r_y);
                w_neg = 1'b0;
                w_src = SRC_ZERO;
            end
            OP_C: begin
                w_a = ext(r_const);
            end
            OP_AR: begin
                w_a = ext(r_ar[i_cmd.lag]);
                w_b = ext(r_sh[w_sh_sel]);
            end
            OP_MA_E: begin
                w_a = ext(r_ma[i_cmd.lag]);
                w_b = ext(r_eh[w_eh_sel]);
            end
            OP_BASE: begin
                if (i_cmd.part == '0)
                    w_a = -L_ONE;
                else if (i_cmd.part <= PART_W'(LAGS))
                    w_a = -ext(r_sh[w_sh_sel]);
                else
                    w_a = -ext(r_eh[w_eh_sel]);
                w_neg = 1'b0;
                w_src = SRC_ZERO;
            end
            OP_MA_D: begin
                w_a = ext(r_ma[i_cmd.lag]);
                w_b = ext(r_dh[i_cmd.part][i_cmd.lag]);
            end
            OP_SCORE: begin
                w_a   = ext(r_der[i_cmd.part]);
                w_b   = ext(r_err);
                w_src = SRC_ZERO;
            end
            OP_SSE: begin
                w_a   = ext(r_err);
                w_b   = ext(r_err);
                w_neg = 1'b0;
                w_src = SRC_SSE;
            end
            default: ;
        endcase
        w_prod   = w_a * w_b;
        w_prod_x = WW'(w_prod);
        if (w_prod_x > WW'(L_MAX))
            w_prod_s = L_MAX;
        else if (w_prod_x < WW'(L_MIN))
            w_prod_s = L_MIN;
        else
            w_prod_s = w_prod_x[ACC_W-1:0];
        if (w_neg)
            w_term = (w_prod_s == L_MIN) ? L_MAX : -w_prod_s;
        else
            w_term = w_prod_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_p_valid <= 1'b0;
        else
            r_p_valid <= i_cmd.mac_en;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_en) begin
            r_p_term <= w_term;
            r_p_src  <= w_src;
        end
    end

    // accumulate stage
    logic signed [ACC_W-1:0] w_acc_base, w_acc_sum;
    always_comb begin
        case (r_p_src)
            SRC_ACC:  w_acc_base = r_acc;
            SRC_SSE:  w_acc_base = r_ss;
            default:  w_acc_base = '0;
        endcase
        w_acc_sum = sat_add(w_acc_base, r_p_term);
    end

    always_ff @(posedge i_clk) begin
        if (r_p_valid && (r_p_src != SRC_SSE))
            r_acc <= w_acc_sum;
    end

    // sample state, write-back and commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_ss  <= '0;
            for (int i = 0; i < LAGS; i++) begin
                r_sh[i] <= '0;
                r_eh[i] <= '0;
                for (int k = 0; k < NPART; k++)
                    r_dh[k][i] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_y   <= i_sample;
                r_err <= '0;
                for (int k = 0; k < NPART; k++) begin
                    r_der[k] <= '0;
                    r_sc[k]  <= '0;
                end
                if (i_series_start) begin
                    r_idx <= '0;
                    r_ss  <= '0;
                    for (int i = 0; i < LAGS; i++) begin
                        r_sh[i] <= '0;
                        r_eh[i] <= '0;
                        for (int k = 0; k < NPART; k++)
                            r_dh[k][i] <= '0;
                    end
                end
            end
            if (r_p_valid && (r_p_src == SRC_SSE))
                r_ss <= w_acc_sum;
            if (i_cmd.wb_err)
                r_err <= to_data(r_acc);
            if (i_cmd.wb_der)
                r_der[i_cmd.part] <= to_data(r_acc);
            if (i_cmd.wb_sc)
                r_sc[i_cmd.part] <= to_data(r_acc);
            if (i_cmd.commit) begin
                if (32'(r_idx) < MAX_ORDER)
                    r_idx <= r_idx + IDX_W'(1);
                for (int i = LAGS - 1; i > 0; i--) begin
                    r_sh[i] <= r_sh[i-1];
                    r_eh[i] <= r_eh[i-1];
                    for (int k = 0; k < NPART; k++)
                        r_dh[k][i] <= r_dh[k][i-1];
                end
                r_sh[0] <= r_y;
                r_eh[0] <= r_err;
                for (int k = 0; k < NPART; k++)
                    r_dh[k][0] <= r_der[k];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            o_out_valid <= 1'b0;
        else if (i_cmd.out_load)
            o_out_valid <= 1'b1;
        else if (i_out_ready)
            o_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_err          <= r_err;
            o_der          <= r_der;
            o_sc           <= r_sc;
            o_half_neg_sse <= -(r_ss >>> 1);
        end
    end

endmodule
`default_nettype wire

// File: src/arma_residual_gradient_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arma_residual_gradient_filter_core
// ARMA(p,q) one-step error, partials, scores and running -0.5*SSE per sample.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | word
//  i_smp   | in  | valid / ready | sample, series_start
//  o_res   | out | valid / ready | error, 5 partials, 5 scores, half_neg_sse
//  i_cfg   | in  | valid / ready | register index, data (ready always high)
//
//  One sample at a time through a single shared MAC (multiply stage, then
//  saturating accumulate). A warm-up word skips the MAC and only commits;
//  otherwise the error terms run, then per active partial (1 + p + q of
//  them) its base, MA terms and score, and last the e * e SSE term.
//  Synchronous active-low reset restores register defaults and clears all
//  histories. A result waits in the output register while the next word is
//  taken; the sequencer stalls only when a new result finds it still full.
// ----------------------------------------------------------------------------
module arma_residual_gradient_filter_core
    import argf_pkg::*;
#(
    parameter int MAX_ORDER  = DEF_MAX_ORDER,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    argf_smp_if.sink   i_smp,
    argf_res_if.source o_res,
    argf_cfg_if.sink   i_cfg
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    logic signed [DATA_WIDTH-1:0] w_err;
    logic signed [DATA_WIDTH-1:0] w_der [NPART];
    logic signed [DATA_WIDTH-1:0] w_sc  [NPART];
    logic signed [ACC_W-1:0]      w_half;
    logic                         w_out_valid;

    // register writes are always taken; the block is idle by contract
    assign i_cfg.ready = 1'b1;
    assign i_smp.ready = w_in_ready;

    argf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    argf_datapath #(
        .MAX_ORDER  (MAX_ORDER),
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_sample       (i_smp.sample),
        .i_series_start (i_smp.series_start),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (w_out_valid),
        .o_err          (w_err),
        .o_der          (w_der),
        .o_sc           (w_sc),
        .o_half_neg_sse (w_half)
    );

    // partial/score slots: constant, AR lag one/two, MA lag one/two
    assign o_res.valid          = w_out_valid;
    assign o_res.forecast_error = w_err;
    assign o_res.deriv_const    = w_der[0];
    assign o_res.deriv_ar_one   = w_der[1];
    assign o_res.deriv_ar_two   = w_der[2];
    assign o_res.deriv_ma_one   = w_der[3];
    assign o_res.deriv_ma_two   = w_der[4];
    assign o_res.score_const    = w_sc[0];
    assign o_res.score_ar_one   = w_sc[1];
    assign o_res.score_ar_two   = w_sc[2];
    assign o_res.score_ma_one   = w_sc[3];
    assign o_res.score_ma_two   = w_sc[4];
    assign o_res.half_neg_sse   = w_half;

    // write-back must never race a term still in the accumulate stage
    a_wb_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.wb_err || w_cmd.wb_der || w_cmd.wb_sc) |-> !w_status.mac_busy)
        else $error("write-back while accumulate stage busy");

    // one word in flight: no second accept right after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |=> !i_smp.ready)
        else $error("input taken twice in a row");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.wb_err, w_cmd.wb_der, w_cmd.wb_sc,
                  w_cmd.commit, w_cmd.out_load}))
        else $error("overlapping sequencer commands");

    a_sse_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.half_neg_sse[63] || (o_res.half_neg_sse == '0)))
        else $error("half_neg_sse positive");

endmodule
`default_nettype wire
